/* rtl/dpc_pkg.sv */
// Shared constants, types and register codes of the DBSCAN point clustering unit.
package dpc_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LBL_W = CNT_W;

  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;

  localparam int IN_W   = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OIDX_W = 6;
  localparam int OLBL_W = 7;
  localparam int OUT_W  = ((OIDX_W + OLBL_W + 7) / 8) * 8;

  localparam int ADDR_W = 4;
  localparam int EPS_W  = 16;
  localparam int MINP_W = 7;

  localparam logic [ADDR_W-3:0] REG_EPS  = 2'd0;
  localparam logic [ADDR_W-3:0] REG_MINP = 2'd1;
  localparam logic [ADDR_W-3:0] REG_MODE = 2'd2;

  localparam logic [LBL_W-1:0] NOISE = '1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [LBL_W-1:0]             label;
    logic                         visited;
    logic                         pending;
  } cell_t;

  typedef struct packed {
    logic             ld_en;
    logic [IDX_W-1:0] ld_idx;
    logic             shift_en;
    logic             upd_en;
  } ring_ctl_t;

endpackage

/* rtl/dpc_cell.sv */
// One cell of the point ring: a stored point with its label and flags.
module dpc_cell (
  input  logic                    clk,
  input  logic [dpc_pkg::IDX_W-1:0] my_idx,
  input  dpc_pkg::ring_ctl_t      ctl,
  input  dpc_pkg::cell_t          ld,
  input  dpc_pkg::cell_t          nb,
  input  dpc_pkg::cell_t          upd,
  output dpc_pkg::cell_t          q
);
  import dpc_pkg::*;

  // A load addresses one cell; a shift takes the neighbour's contents; an update takes upd.
  always_ff @(posedge clk) begin
    if (ctl.ld_en && (ctl.ld_idx == my_idx)) begin
      q <= ld;
    end else if (ctl.shift_en) begin
      q <= nb;
    end else if (ctl.upd_en) begin
      q <= upd;
    end
  end

endmodule

/* rtl/dpc_dist.sv */
// Two-stage squared distance test between the ring head and the query point.
module dpc_dist (
  input  logic                             clk,
  input  dpc_pkg::cell_t                   a,
  input  logic signed [dpc_pkg::COORD_BITS-1:0] qx,
  input  logic signed [dpc_pkg::COORD_BITS-1:0] qy,
  input  logic signed [dpc_pkg::COORD_BITS-1:0] qz,
  input  logic [31:0]                      eps_sq,
  output logic                             in_range
);
  import dpc_pkg::*;

  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [COORD_BITS:0]        mx, my, mz;
  logic [SQ_W-1:0]            sx, sy, sz;
  logic [SQ_W-1:0]            sum;

  always_comb begin
    dx = (COORD_BITS+1)'(a.x) - (COORD_BITS+1)'(qx);
    dy = (COORD_BITS+1)'(a.y) - (COORD_BITS+1)'(qy);
    dz = (COORD_BITS+1)'(a.z) - (COORD_BITS+1)'(qz);
    mx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
    my = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
    mz = dz[COORD_BITS] ? (COORD_BITS+1)'(-dz) : (COORD_BITS+1)'(dz);
  end

  always_ff @(posedge clk) begin
    sx <= SQ_W'(mx) * SQ_W'(mx);
    sy <= SQ_W'(my) * SQ_W'(my);
    sz <= SQ_W'(mz) * SQ_W'(mz);
  end

  // The sum cannot overflow: three squares of at most 2^(2*COORD_BITS).
  assign sum      = sx + sy + sz;
  assign in_range = CMP_W'(sum) <= CMP_W'(eps_sq);

endmodule

/* rtl/dbscan_point_clustering_unit.sv */
// Top level of the DBSCAN point clustering unit: ring of point cells and pass sequencer.
//
//   channel   | kind          | contents
//   s_axis    | stream in     | tdata: coord_x, coord_y, coord_z; tuser: last_point
//   m_axis    | stream out    | tdata: point_index, cluster_label; tlast: last_result;
//             |               | tuser: empty_set
//   apb       | register port | eps_radius at 0x0, min_pts at 0x4, output_mode at 0x8
//
// Points load at one transaction per cycle while loading. Clustering works in passes over a
// ring of MAX_POINTS cells that rotates once per pass, with a closing step after the rotation
// to settle the last point's update. Each point costs a search pass, a neighbour count pass
// and, for a core point, a marking pass. Mode 1 adds one counting pass per cluster.
// Reset is synchronous and needs no clearing sweep. A stalled output holds the ring.
module dbscan_point_clustering_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
  input  logic [dpc_pkg::IN_W-1:0]      s_axis_tdata,
  // last_point [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // point_index [5:0], cluster_label [12:6], zero fill above
  output logic [dpc_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                          m_axis_tlast,
  // empty_set [0]
  output logic                          m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dpc_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SEEK  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_SIZE  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  logic [2:0]         state;
  logic [EPS_W-1:0]   eps_radius;
  logic [MINP_W-1:0]  min_pts;
  logic               output_mode;
  logic [31:0]        eps_sq;

  logic [CNT_W-1:0]   cnt, step, pend_cnt, nxt_cl, nbr_cnt;
  logic [CNT_W-1:0]   cid, cur_size, best_id, top_size, seen;
  logic               found, tgt_seed, tgt_needq;
  logic [IDX_W-1:0]   tgt_idx, idx_d;
  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic               act_d, pick_d, pmode_d;

  cell_t              cq [MAX_POINTS];
  cell_t              ld_cell, head, tail, tail_mod;
  ring_ctl_t          ctl;
  logic               in_range;

  logic [IDX_W-1:0]   head_idx;
  logic               head_ok, at_flush, pass_st, emit_hit, out_free, emit_stall;
  logic               shift_now, pick, mark_set, load_acc, room, core, out_ld;
  logic [CNT_W-1:0]   cur_id, nbr_total;
  logic [OLBL_W-1:0]  out_lbl;
  logic               out_last;

  // Configuration port: writes complete in the access phase, reads are combinational.
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_EPS:  prdata = 32'(eps_radius);
      REG_MINP: prdata = 32'(min_pts);
      REG_MODE: prdata = 32'(output_mode);
      default:  prdata = '0;
    endcase
  end

  // The head cell is the point whose index equals the pass step; the tail cell holds the
  // point seen in the previous cycle, whose distance result arrives now and is applied to it.
  assign head     = cq[0];
  assign tail     = cq[MAX_POINTS-1];
  assign head_idx = step[IDX_W-1:0];
  assign head_ok  = step < cnt;
  assign at_flush = step == CNT_W'(MAX_POINTS);
  assign pass_st  = (state == ST_SEEK) || (state == ST_COUNT) || (state == ST_MARK) ||
                    (state == ST_SIZE) || (state == ST_EMIT);
  assign emit_hit = output_mode ? (head.label == best_id) : 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit_stall = (state == ST_EMIT) && head_ok && emit_hit && !out_free;
  assign shift_now  = pass_st && !at_flush && !emit_stall;
  assign cur_id     = nxt_cl - 1'b1;

  // Expansion takes the lowest pending point first; with none pending, the lowest
  // unvisited point is taken and seeds a new cluster if it is a core point.
  assign pick = (state == ST_SEEK) && shift_now && head_ok && !found &&
                ((pend_cnt != '0) ? head.pending : !head.visited);

  assign mark_set = (state == ST_MARK) && act_d && !((idx_d == tgt_idx) && tgt_seed) &&
                    in_range && (!tail.visited || (tail.label == NOISE)) && !tail.pending;

  assign nbr_total = nbr_cnt + CNT_W'(act_d && in_range);
  assign core      = 32'(nbr_total) >= 32'(min_pts);

  assign load_acc = s_axis_tvalid && s_axis_tready;
  assign room     = cnt < CNT_W'(MAX_POINTS);
  assign s_axis_tready = (state == ST_LOAD);

  always_comb begin
    tail_mod = tail;
    if (act_d && (state == ST_SEEK) && pick_d) begin
      tail_mod.pending = 1'b0;
      tail_mod.visited = 1'b1;
      if (pmode_d && (tail.label == NOISE)) begin
        tail_mod.label = cur_id;
      end
    end else if (act_d && (state == ST_MARK)) begin
      if ((idx_d == tgt_idx) && tgt_seed) begin
        tail_mod.label = cur_id;
      end else if (mark_set) begin
        tail_mod.pending = 1'b1;
      end
    end
  end

  always_comb begin
    ld_cell         = '0;
    ld_cell.x       = s_axis_tdata[COORD_BITS-1:0];
    ld_cell.y       = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    ld_cell.z       = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    ld_cell.label   = NOISE;
    ctl.ld_en    = load_acc && room;
    ctl.ld_idx   = cnt[IDX_W-1:0];
    ctl.shift_en = shift_now;
    ctl.upd_en   = at_flush;
  end

  // The ring: each cell passes its point to the next lower cell, the head wraps to the
  // tail, and the update of the tail point is folded into its next move.
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
    cell_t     nb_k;
    ring_ctl_t ctl_k;
    if (k == MAX_POINTS - 1) begin : g_tail
      assign nb_k = cq[0];
    end else if (k == MAX_POINTS - 2) begin : g_pre
      assign nb_k = tail_mod;
    end else begin : g_mid
      assign nb_k = cq[k+1];
    end
    always_comb begin
      ctl_k        = ctl;
      ctl_k.upd_en = ctl.upd_en && (k == MAX_POINTS - 1);
    end
    dpc_cell u_cell (
      .clk    (clk),
      .my_idx (IDX_W'(k)),
      .ctl    (ctl_k),
      .ld     (ld_cell),
      .nb     (nb_k),
      .upd    (tail_mod),
      .q      (cq[k])
    );
  end

  dpc_dist u_dist (
    .clk      (clk),
    .a        (head),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .eps_sq   (eps_sq),
    .in_range (in_range)
  );

  // Result fields for the point at the head.
  assign out_lbl  = (head.label == NOISE) ? '1 : OLBL_W'(head.label);
  assign out_last = output_mode ? ((seen + 1'b1) == top_size) : (step == (cnt - 1'b1));
  assign out_ld   = (state == ST_EMIT) && shift_now && head_ok && emit_hit;

  always_ff @(posedge clk) begin
    eps_sq <= 32'(eps_radius) * 32'(eps_radius);
    act_d  <= shift_now && head_ok &&
              ((state == ST_SEEK) || (state == ST_COUNT) || (state == ST_MARK));
    idx_d  <= head_idx;
    pick_d <= pick;
    pmode_d <= pend_cnt != '0;
    if (pick) begin
      tgt_idx   <= head_idx;
      qx        <= head.x;
      qy        <= head.y;
      qz        <= head.z;
      tgt_seed  <= pend_cnt == '0;
      tgt_needq <= !head.visited;
    end
    if (out_ld) begin
      m_axis_tdata <= OUT_W'({out_lbl, OIDX_W'(head_idx)});
      m_axis_tlast <= out_last;
      m_axis_tuser <= 1'b0;
    end else if ((state == ST_EMPTY) && out_free) begin
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b1;
      m_axis_tuser <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      eps_radius    <= EPS_W'(256);
      min_pts       <= MINP_W'(4);
      output_mode   <= 1'b0;
      cnt           <= '0;
      step          <= '0;
      pend_cnt      <= '0;
      nxt_cl        <= '0;
      nbr_cnt       <= '0;
      cid           <= '0;
      cur_size      <= '0;
      best_id       <= '0;
      top_size      <= '0;
      seen          <= '0;
      found         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[ADDR_W-1:2])
          REG_EPS:  eps_radius  <= pwdata[EPS_W-1:0];
          REG_MINP: min_pts     <= pwdata[MINP_W-1:0];
          REG_MODE: output_mode <= pwdata[0];
          default:  ;
        endcase
      end

      if (out_ld || ((state == ST_EMPTY) && out_free)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (shift_now) begin
        step <= step + 1'b1;
      end

      unique case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (room) begin
              cnt <= cnt + 1'b1;
            end
            if (s_axis_tuser) begin
              state    <= ST_SEEK;
              step     <= '0;
              pend_cnt <= '0;
              nxt_cl   <= '0;
              found    <= 1'b0;
            end
          end
        end
        ST_SEEK: begin
          if (pick) begin
            found <= 1'b1;
            if (pend_cnt != '0) begin
              pend_cnt <= pend_cnt - 1'b1;
            end
          end
          if (at_flush) begin
            step    <= '0;
            found   <= 1'b0;
            nbr_cnt <= '0;
            if (!found) begin
              cid       <= '0;
              cur_size  <= '0;
              best_id   <= '0;
              top_size  <= '0;
              seen      <= '0;
              if (!output_mode) begin
                state <= ST_EMIT;
              end else if (nxt_cl == '0) begin
                state <= ST_EMPTY;
              end else begin
                state <= ST_SIZE;
              end
            end else if (tgt_needq) begin
              state <= ST_COUNT;
            end else begin
              state <= ST_SEEK;
            end
          end
        end
        ST_COUNT: begin
          if (act_d && in_range) begin
            nbr_cnt <= nbr_cnt + 1'b1;
          end
          if (at_flush) begin
            step <= '0;
            if (core) begin
              if (tgt_seed) begin
                nxt_cl <= nxt_cl + 1'b1;
              end
              state <= ST_MARK;
            end else begin
              state <= ST_SEEK;
            end
          end
        end
        ST_MARK: begin
          if (mark_set) begin
            pend_cnt <= pend_cnt + 1'b1;
          end
          if (at_flush) begin
            step  <= '0;
            state <= ST_SEEK;
          end
        end
        ST_SIZE: begin
          if (shift_now && head_ok && (head.label == cid)) begin
            cur_size <= cur_size + 1'b1;
          end
          if (at_flush) begin
            step     <= '0;
            cur_size <= '0;
            if (cur_size > top_size) begin
              top_size <= cur_size;
              best_id  <= cid;
            end
            if (cid == cur_id) begin
              state <= ST_EMIT;
            end else begin
              cid <= cid + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_ld) begin
            seen <= seen + 1'b1;
          end
          if (at_flush) begin
            step  <= '0;
            cnt   <= '0;
            state <= ST_LOAD;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            cnt   <= '0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* rtl/dpc_checker.sv */
// Port-level checks on the DBSCAN point clustering unit, bound to the top level.
module dpc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [dpc_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser,
  input logic                      pready
);
  import dpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input taken after the last point of a set");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("empty-set result malformed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("register port not ready");

endmodule

bind dbscan_point_clustering_unit dpc_checker u_dpc_checker (.*);
